// ----- src/ifdr_pkg.sv -----
`timescale 1ns / 1ps
package ifdr_pkg;

   localparam int DIM_BITS_DEF        = 14;
   localparam int SCALE_FRAC_BITS_DEF = 8;
   localparam int REG_BITS            = 16;
   localparam int OUT_BITS            = 16;
   localparam int CSR_IDX_BITS        = 2;
   // destination sizes saturate at 2**DEST_QBITS - 1
   localparam int DEST_QBITS          = 15;
   localparam logic [OUT_BITS-1:0] DEST_MAX = 16'd32767;

   localparam logic [REG_BITS-1:0] CENTER_SCALE_RST = 16'd256;
   localparam logic [REG_BITS-1:0] SCALE_MIN_RST    = 16'd26;
   localparam logic [REG_BITS-1:0] SCALE_MAX_RST    = 16'd2560;

   typedef enum logic [2:0] {
      MODE_STRETCH = 3'd0,
      MODE_FILL    = 3'd1,
      MODE_FIT     = 3'd2,
      MODE_CENTER  = 3'd3,
      MODE_TILE    = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CENTER_SCALE = 2'd0,
      CSR_SCALE_MIN    = 2'd1,
      CSR_SCALE_MAX    = 2'd2
   } csr_idx_type;

endpackage

// ----- src/ifdr_req_if.sv -----
`timescale 1ns / 1ps
interface ifdr_req_if #(parameter int DIM_BITS = ifdr_pkg::DIM_BITS_DEF) ();
   logic                valid;
   logic                ready;
   logic [2:0]          mode;
   logic [DIM_BITS-1:0] image_w;
   logic [DIM_BITS-1:0] image_h;
   logic [DIM_BITS-1:0] area_w;
   logic [DIM_BITS-1:0] area_h;

   modport source (output valid, mode, image_w, image_h, area_w, area_h, input ready);
   modport sink   (input valid, mode, image_w, image_h, area_w, area_h, output ready);
endinterface

// ----- src/ifdr_rsp_if.sv -----
`timescale 1ns / 1ps
interface ifdr_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [15:0] rect_left;
   logic signed [15:0] rect_bottom;
   logic signed [15:0] rect_right;
   logic signed [15:0] rect_top;

   modport source (output valid, rect_left, rect_bottom, rect_right, rect_top, input ready);
   modport sink   (input valid, rect_left, rect_bottom, rect_right, rect_top, output ready);
endinterface

// ----- src/ifdr_csr_if.sv -----
`timescale 1ns / 1ps
interface ifdr_csr_if ();
   logic                                 valid;
   logic                                 ready;
   logic [ifdr_pkg::CSR_IDX_BITS-1:0]    index;
   logic [ifdr_pkg::REG_BITS-1:0]        wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- src/ifdr_cell.sv -----
`timescale 1ns / 1ps
// One restoring-division step: test the remainder against the divisor shifted
// by K. The top cell (K == QB) only flags a quotient that overflows QB bits.
module ifdr_cell #(
   parameter int CW = 34,
   parameter int DW = 15,
   parameter int QB = 15,
   parameter int K  = 0
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [CW-1:0] rem_i,
   input  logic [DW-1:0] d_i,
   input  logic [QB-1:0] q_i,
   input  logic          sat_i,
   output logic [CW-1:0] rem_o,
   output logic [DW-1:0] d_o,
   output logic [QB-1:0] q_o,
   output logic          sat_o
);
   logic [CW-1:0] rem_ff, rem_in, dsh;
   logic [DW-1:0] d_ff;
   logic [QB-1:0] q_ff, q_in;
   logic          sat_ff, sat_in;
   logic          ge;

   assign dsh = CW'(d_i) << K;
   assign ge  = rem_i >= dsh;

   if (K == QB) begin : g_sat
      assign rem_in = rem_i;
      assign q_in   = q_i;
      assign sat_in = sat_i | ge;
   end else begin : g_bit
      assign rem_in = ge ? rem_i - dsh : rem_i;
      assign q_in   = q_i | (QB'(ge) << K);
      assign sat_in = sat_i;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         d_ff   <= d_i;
         q_ff   <= q_in;
         sat_ff <= sat_in;
      end
   end

   assign rem_o = rem_ff;
   assign d_o   = d_ff;
   assign q_o   = q_ff;
   assign sat_o = sat_ff;
endmodule

// ----- src/image_fit_dest_rect.sv -----
`timescale 1ns / 1ps
// Destination rectangle for placing an image into an area. One request item in,
// one rectangle item out, a new item every cycle unless the output stalls. Stages:
// a product stage, a select/multiply stage, a row of one-bit restoring-division
// cells (one per quotient bit plus an overflow cell) for each of the two dimensions,
// and the output register. A stalled output holds the whole pipeline. Fit/fill
// scale by the smaller/larger area-to-image ratio, center by the clamped register
// scale (1.0 if the register is zero); stretch, tile, undefined modes and any zero
// size give the whole area. Registers are written through the csr channel.
module image_fit_dest_rect #(
   parameter int DIM_BITS        = ifdr_pkg::DIM_BITS_DEF,
   parameter int SCALE_FRAC_BITS = ifdr_pkg::SCALE_FRAC_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   ifdr_req_if.sink    req_ch,
   ifdr_rsp_if.source  rsp_ch,
   ifdr_csr_if.sink    csr_ch
);
   localparam int QB   = ifdr_pkg::DEST_QBITS;
   localparam int NUMW = (SCALE_FRAC_BITS + 1 > 16) ? SCALE_FRAC_BITS + 1 : 16;
   localparam int DENW = (DIM_BITS > SCALE_FRAC_BITS + 1) ? DIM_BITS : SCALE_FRAC_BITS + 1;
   localparam int DW   = DENW + 1;
   localparam int PRW  = DIM_BITS + NUMW;
   localparam int NW   = PRW + 2;
   localparam int CW   = ((NW > DW + QB) ? NW : DW + QB) + 1;
   localparam int NC   = QB + 1;
   localparam int XW   = 18;
   localparam logic [NUMW-1:0] ONE = NUMW'(1) << SCALE_FRAC_BITS;

   // registers
   logic [15:0] center_scale_ff, scale_min_ff, scale_max_ff;
   logic        adv;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_scale_ff <= ifdr_pkg::CENTER_SCALE_RST;
         scale_min_ff    <= ifdr_pkg::SCALE_MIN_RST;
         scale_max_ff    <= ifdr_pkg::SCALE_MAX_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ifdr_pkg::CSR_CENTER_SCALE: center_scale_ff <= csr_ch.wdata;
            ifdr_pkg::CSR_SCALE_MIN:    scale_min_ff    <= csr_ch.wdata;
            ifdr_pkg::CSR_SCALE_MAX:    scale_max_ff    <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // stage 1: cross products, clamped scale, mode class
   logic                v1_ff;
   logic                whole1_ff, center1_ff, fit1_ff;
   logic [DIM_BITS-1:0] iw1_ff, ih1_ff, aw1_ff, ah1_ff;
   logic [NUMW-1:0]     s1_ff, s1_in;
   logic [2*DIM_BITS-1:0] pa1_ff, pb1_ff;
   logic                whole1_in, zero_in;
   logic [15:0]         lo_s;

   assign lo_s    = (center_scale_ff < scale_min_ff) ? scale_min_ff : center_scale_ff;
   assign s1_in   = (center_scale_ff == 16'd0) ? ONE :
                    NUMW'((lo_s > scale_max_ff) ? scale_max_ff : lo_s);
   assign zero_in = (req_ch.image_w == '0) || (req_ch.image_h == '0) ||
                    (req_ch.area_w == '0) || (req_ch.area_h == '0);
   assign whole1_in = zero_in || !(req_ch.mode == ifdr_pkg::MODE_FILL ||
                      req_ch.mode == ifdr_pkg::MODE_FIT || req_ch.mode == ifdr_pkg::MODE_CENTER);

   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_ch.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         whole1_ff  <= whole1_in;
         center1_ff <= req_ch.mode == ifdr_pkg::MODE_CENTER;
         fit1_ff    <= req_ch.mode == ifdr_pkg::MODE_FIT;
         iw1_ff     <= req_ch.image_w;
         ih1_ff     <= req_ch.image_h;
         aw1_ff     <= req_ch.area_w;
         ah1_ff     <= req_ch.area_h;
         s1_ff      <= s1_in;
         pa1_ff     <= (2*DIM_BITS)'(req_ch.area_w) * (2*DIM_BITS)'(req_ch.image_h);
         pb1_ff     <= (2*DIM_BITS)'(req_ch.area_h) * (2*DIM_BITS)'(req_ch.image_w);
      end
   end

   // stage 2: pick the ratio, form numerators 2*dim*num + den and divisor 2*den
   logic            x_smaller, use_x;
   logic [NUMW-1:0] num2;
   logic [DENW-1:0] den2;
   logic [PRW-1:0]  prw, prh;
   logic            v2_ff, whole2_ff;
   logic [DIM_BITS-1:0] aw2_ff, ah2_ff;
   logic [NW-1:0]   nw2_ff, nh2_ff;
   logic [DW-1:0]   d2_ff;

   assign x_smaller = pa1_ff <= pb1_ff;
   assign use_x     = fit1_ff ? x_smaller : !x_smaller;
   assign num2 = center1_ff ? s1_ff : NUMW'(use_x ? aw1_ff : ah1_ff);
   assign den2 = center1_ff ? DENW'(ONE) : DENW'(use_x ? iw1_ff : ih1_ff);
   assign prw  = PRW'(iw1_ff) * PRW'(num2);
   assign prh  = PRW'(ih1_ff) * PRW'(num2);

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         whole2_ff <= whole1_ff;
         aw2_ff    <= aw1_ff;
         ah2_ff    <= ah1_ff;
         nw2_ff    <= NW'({prw, 1'b0}) + NW'(den2);
         nh2_ff    <= NW'({prh, 1'b0}) + NW'(den2);
         d2_ff     <= {den2, 1'b0};
      end
   end

   // division cells, both dimensions in lockstep, sideband alongside
   logic [CW-1:0] rw [0:NC], rh [0:NC];
   logic [DW-1:0] dw_c [0:NC], dh_c [0:NC];
   logic [QB-1:0] qw [0:NC], qh [0:NC];
   logic          sw [0:NC], sh [0:NC];
   logic          vs_ff [1:NC];
   logic          whs_ff [1:NC];
   logic [DIM_BITS-1:0] aws_ff [1:NC], ahs_ff [1:NC];

   assign rw[0] = CW'(nw2_ff);
   assign rh[0] = CW'(nh2_ff);
   assign dw_c[0] = d2_ff;
   assign dh_c[0] = d2_ff;
   assign qw[0] = '0;
   assign qh[0] = '0;
   assign sw[0] = 1'b0;
   assign sh[0] = 1'b0;

   for (genvar i = 0; i < NC; i++) begin : g_row
      ifdr_cell #(.CW(CW), .DW(DW), .QB(QB), .K(QB - i)) u_w (
         .clock(clock), .adv(adv),
         .rem_i(rw[i]), .d_i(dw_c[i]), .q_i(qw[i]), .sat_i(sw[i]),
         .rem_o(rw[i+1]), .d_o(dw_c[i+1]), .q_o(qw[i+1]), .sat_o(sw[i+1]));
      ifdr_cell #(.CW(CW), .DW(DW), .QB(QB), .K(QB - i)) u_h (
         .clock(clock), .adv(adv),
         .rem_i(rh[i]), .d_i(dh_c[i]), .q_i(qh[i]), .sat_i(sh[i]),
         .rem_o(rh[i+1]), .d_o(dh_c[i+1]), .q_o(qh[i+1]), .sat_o(sh[i+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NC; k++) vs_ff[k] <= 1'b0;
      end else if (adv) begin
         vs_ff[1] <= v2_ff;
         for (int k = 2; k <= NC; k++) vs_ff[k] <= vs_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         whs_ff[1] <= whole2_ff;
         aws_ff[1] <= aw2_ff;
         ahs_ff[1] <= ah2_ff;
         for (int k = 2; k <= NC; k++) begin
            whs_ff[k] <= whs_ff[k-1];
            aws_ff[k] <= aws_ff[k-1];
            ahs_ff[k] <= ahs_ff[k-1];
         end
      end
   end

   // final: clamp sizes, center offsets, output register
   logic [15:0]          destw, desth, sizew, sizeh;
   logic signed [XW-1:0] diffw, diffh, leftx, botx;
   logic                 rsp_valid_ff;
   logic signed [15:0]   left_ff, bottom_ff, right_ff, top_ff;

   assign destw = sw[NC] ? ifdr_pkg::DEST_MAX : ((qw[NC] == '0) ? 16'd1 : 16'(qw[NC]));
   assign desth = sh[NC] ? ifdr_pkg::DEST_MAX : ((qh[NC] == '0) ? 16'd1 : 16'(qh[NC]));
   // whole area: size equals area, so the offset comes out zero
   assign sizew = whs_ff[NC] ? 16'(aws_ff[NC]) : destw;
   assign sizeh = whs_ff[NC] ? 16'(ahs_ff[NC]) : desth;
   assign diffw = $signed(XW'(aws_ff[NC])) - $signed(XW'(sizew));
   assign diffh = $signed(XW'(ahs_ff[NC])) - $signed(XW'(sizeh));
   // truncate toward zero
   assign leftx = (diffw + $signed(XW'(diffw[XW-1]))) >>> 1;
   assign botx  = (diffh + $signed(XW'(diffh[XW-1]))) >>> 1;

   assign adv = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vs_ff[NC];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff   <= leftx[15:0];
         bottom_ff <= botx[15:0];
         right_ff  <= leftx[15:0] + sizew;
         top_ff    <= botx[15:0] + sizeh;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.rect_left   = left_ff;
   assign rsp_ch.rect_bottom = bottom_ff;
   assign rsp_ch.rect_right  = right_ff;
   assign rsp_ch.rect_top    = top_ff;
endmodule

// ----- src/ifdr_checker.sv -----
`timescale 1ns / 1ps
module ifdr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_left,
   input logic [15:0] rsp_top
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_top))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output backpressure");
endmodule

bind image_fit_dest_rect ifdr_checker u_ifdr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_left  (rsp_ch.rect_left),
   .rsp_top   (rsp_ch.rect_top)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   localparam int DW = ifdr_pkg::DIM_BITS_DEF;
   localparam int FRAC = ifdr_pkg::SCALE_FRAC_BITS_DEF;
   localparam int LATENCY = 19;

   typedef struct packed {
      logic [2:0]    mode;
      logic [DW-1:0] image_w;
      logic [DW-1:0] image_h;
      logic [DW-1:0] area_w;
      logic [DW-1:0] area_h;
   } layout_req_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] bottom;
      logic [15:0] right;
      logic [15:0] top;
   } rect_type;

   typedef struct {
      layout_req_type req;
      logic           has_rect;
      rect_type       rect;
   } layout_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ifdr_req_if #(.DIM_BITS(DW)) req_ch ();
   ifdr_rsp_if rsp_ch ();
   ifdr_csr_if csr_ch ();

   image_fit_dest_rect u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   logic [15:0] center_scale_q = ifdr_pkg::CENTER_SCALE_RST;
   logic [15:0] scale_min_q    = ifdr_pkg::SCALE_MIN_RST;
   logic [15:0] scale_max_q    = ifdr_pkg::SCALE_MAX_RST;

   rect_type rect_queue[$];
   int       error_count = 0;
   bit       stim_done = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic longint scale_dim(longint dim, longint num, longint den);
      longint v;
      v = (2 * dim * num + den) / (2 * den);
      if (v < 1) v = 1;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function automatic rect_type place_rect(layout_req_type r);
      longint   iw, ih, aw, ah, dw, dh, lf, bt, s, num, den;
      bit       x_smaller, use_x;
      rect_type o;
      iw = r.image_w; ih = r.image_h; aw = r.area_w; ah = r.area_h;
      lf = 0; bt = 0; dw = aw; dh = ah;
      if (!(iw == 0 || ih == 0 || aw == 0 || ah == 0 || r.mode == ifdr_pkg::MODE_STRETCH ||
            r.mode >= ifdr_pkg::MODE_TILE)) begin
         if (r.mode == ifdr_pkg::MODE_CENTER) begin
            s = center_scale_q;
            if (s == 0) begin
               s = 1 << FRAC;
            end else begin
               if (s < scale_min_q) s = scale_min_q;
               if (s > scale_max_q) s = scale_max_q;
            end
            dw = scale_dim(iw, s, 1 << FRAC);
            dh = scale_dim(ih, s, 1 << FRAC);
         end else begin
            x_smaller = (aw * ih) <= (ah * iw);
            use_x = (r.mode == ifdr_pkg::MODE_FIT) ? x_smaller : !x_smaller;
            num = use_x ? aw : ah;
            den = use_x ? iw : ih;
            dw = scale_dim(iw, num, den);
            dh = scale_dim(ih, num, den);
         end
         lf = (aw - dw) / 2;
         bt = (ah - dh) / 2;
      end
      o.left = lf[15:0];
      o.bottom = bt[15:0];
      o.right = 16'(lf + dw);
      o.top = 16'(bt + dh);
      return o;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   function automatic logic [DW-1:0] rand_dim();
      case ($urandom_range(0, 5))
         0: return {DW{1'b1}};
         1: return DW'($urandom_range(1, 16));
         2: return DW'($urandom_range(0, 3));
         default: return DW'($urandom());
      endcase
   endfunction

   task automatic send_req(layout_req_type r, bit has_rect, rect_type rect);
      int g;
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      repeat (g) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.mode <= r.mode; req_ch.image_w <= r.image_w; req_ch.image_h <= r.image_h;
      req_ch.area_w <= r.area_w; req_ch.area_h <= r.area_h;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // table rows with a typed result are checked against that result
      rect_queue = {rect_queue, has_rect ? rect : place_rect(r)};
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (rect_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic csr_write(ifdr_pkg::csr_idx_type idx, logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.wdata <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         ifdr_pkg::CSR_CENTER_SCALE: center_scale_q = val;
         ifdr_pkg::CSR_SCALE_MIN:    scale_min_q = val;
         default:                    scale_max_q = val;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_items(int n);
      layout_req_type r;
      rect_type dummy;
      dummy = '0;
      repeat (n) begin
         r.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
         r.image_w = rand_dim(); r.image_h = rand_dim();
         r.area_w = rand_dim(); r.area_h = rand_dim();
         send_req(r, 1'b0, dummy);
      end
   endtask

   layout_row_type dir_rows[$];

   function automatic void add_row(logic [2:0] m, int iw, int ih, int aw, int ah,
                                   bit hr, int l, int b, int rt, int tp);
      layout_row_type t;
      t.req = '{m, DW'(iw), DW'(ih), DW'(aw), DW'(ah)};
      t.has_rect = hr;
      t.rect = '{16'(l), 16'(b), 16'(rt), 16'(tp)};
      dir_rows = {dir_rows, t};
   endfunction

   initial begin
      logic [15:0] v;
      req_ch.valid = 0; req_ch.mode = '0; req_ch.image_w = '0; req_ch.image_h = '0;
      req_ch.area_w = '0; req_ch.area_h = '0;
      csr_ch.valid = 0; csr_ch.index = '0; csr_ch.wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(ifdr_pkg::MODE_STRETCH, 10, 10, 100, 50, 1, 0, 0, 100, 50);
      add_row(ifdr_pkg::MODE_TILE, 10, 10, 100, 50, 1, 0, 0, 100, 50);
      add_row(3'd5, 10, 10, 100, 50, 1, 0, 0, 100, 50);
      add_row(3'd7, 10, 10, 100, 50, 1, 0, 0, 100, 50);
      add_row(ifdr_pkg::MODE_FIT, 0, 10, 100, 50, 1, 0, 0, 100, 50);
      add_row(ifdr_pkg::MODE_FILL, 10, 0, 100, 50, 1, 0, 0, 100, 50);
      add_row(ifdr_pkg::MODE_CENTER, 10, 10, 0, 50, 1, 0, 0, 0, 50);
      add_row(ifdr_pkg::MODE_FIT, 10, 10, 100, 0, 1, 0, 0, 100, 0);
      add_row(ifdr_pkg::MODE_FIT, 10, 10, 100, 50, 1, 25, 0, 75, 50);
      add_row(ifdr_pkg::MODE_FILL, 10, 10, 100, 50, 1, 0, -25, 100, 75);
      add_row(ifdr_pkg::MODE_CENTER, 10, 20, 100, 50, 1, 45, 15, 55, 35);
      add_row(ifdr_pkg::MODE_FIT, 20, 10, 40, 20, 1, 0, 0, 40, 20);
      add_row(ifdr_pkg::MODE_FIT, 16383, 16383, 16383, 16383, 0, 0, 0, 0, 0);
      add_row(ifdr_pkg::MODE_FILL, 1, 16383, 16383, 1, 0, 0, 0, 0, 0);
      add_row(ifdr_pkg::MODE_FIT, 1, 16383, 16383, 1, 0, 0, 0, 0, 0);
      add_row(ifdr_pkg::MODE_FILL, 1, 1, 16383, 16383, 0, 0, 0, 0, 0);
      add_row(ifdr_pkg::MODE_CENTER, 16383, 1, 16383, 1, 0, 0, 0, 0, 0);
      add_row(ifdr_pkg::MODE_FIT, 3, 7, 5, 11, 0, 0, 0, 0, 0);
      foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_rect, dir_rows[i].rect);
      random_items(60);
      wait_idle();

      // extremes of the clamp, inverted bounds and a zero center scale
      csr_write(ifdr_pkg::CSR_CENTER_SCALE, 16'hFFFF);
      csr_write(ifdr_pkg::CSR_SCALE_MAX, 16'hFFFF);
      csr_write(ifdr_pkg::CSR_SCALE_MIN, 16'd1);
      random_items(60); wait_idle();
      csr_write(ifdr_pkg::CSR_CENTER_SCALE, 16'd0);
      random_items(40); wait_idle();
      csr_write(ifdr_pkg::CSR_CENTER_SCALE, 16'd1);
      csr_write(ifdr_pkg::CSR_SCALE_MIN, 16'd0);
      random_items(40); wait_idle();
      csr_write(ifdr_pkg::CSR_SCALE_MIN, 16'd3000);
      csr_write(ifdr_pkg::CSR_SCALE_MAX, 16'd100);
      random_items(40); wait_idle();
      csr_write(ifdr_pkg::CSR_SCALE_MIN, 16'hFFFF);
      csr_write(ifdr_pkg::CSR_SCALE_MAX, 16'd1);
      random_items(40); wait_idle();
      repeat (6) begin
         v = 16'($urandom());
         csr_write(ifdr_pkg::CSR_CENTER_SCALE, v);
         csr_write(ifdr_pkg::CSR_SCALE_MIN, 16'($urandom_range(0, 65535)));
         csr_write(ifdr_pkg::CSR_SCALE_MAX, 16'($urandom_range(0, 65535)));
         random_items(45); wait_idle();
      end
      stim_done = 1;
   end

   // response side: random backpressure, compare against the oldest prediction
   initial begin
      rect_type got, exp_r;
      int g;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
         if (g != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.rect_left, rsp_ch.rect_bottom, rsp_ch.rect_right, rsp_ch.rect_top};
            if (rect_queue.size() == 0) begin
               $display("%0t unexpected item: got %h", $time, got);
               error_count++;
            end else begin
               exp_r = rect_queue.pop_front();
               if (got.left !== exp_r.left || got.bottom !== exp_r.bottom ||
                   got.right !== exp_r.right || got.top !== exp_r.top) begin
                  $display("%0t rect mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                           $time, $signed(exp_r.left), $signed(exp_r.bottom),
                           $signed(exp_r.right), $signed(exp_r.top), $signed(got.left),
                           $signed(got.bottom), $signed(got.right), $signed(got.top));
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      repeat (LATENCY + 10) @(posedge clock);
      if (rect_queue.size() != 0) begin
         $display("%0t missing items: exp 0 left got %0d", $time, rect_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
